// ===== hw/rtl/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: shared definitions
// Widths, CORDIC arctangent table, axis and register codes.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int unsigned ANGLE_BITS_DEF     = 16;
  localparam int unsigned COMPONENT_BITS_DEF = 16;

  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned CW = 40;   // CORDIC x/y datapath
  localparam int unsigned MW = 34;   // rotation matrix entry, Q.28
  localparam int unsigned ZW = 34;   // rotation-mode residual angle

  localparam logic signed [31:0] INV_GAIN  = 32'sd652032874;
  localparam logic [31:0]        HALF_TURN = 32'h8000_0000;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10680862,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [1:0] {
    REG_AXIS_FIRST  = 2'd0,
    REG_AXIS_SECOND = 2'd1,
    REG_AXIS_THIRD  = 2'd2
  } reg_idx_e;

endpackage

// ===== hw/rtl/qte_vec.sv =====
// ----------------------------------------------------------------------------
// Vectoring CORDIC pipeline
// Angle and scaled length of (x, y); one input stage, then one step per stage.
// ----------------------------------------------------------------------------
module qte_vec #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [qte_pkg::CW-1:0] x_i,
  input  logic signed [qte_pkg::CW-1:0] y_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic signed [qte_pkg::CW-1:0] x_o,
  output logic [31:0]                 z_o,
  output logic [SIDE_W-1:0]           side_o
);
  import qte_pkg::*;

  localparam int unsigned N = CORDIC_STEPS;

  logic [N:0]             v_q;
  logic [N:0]             zero_q;
  logic signed [CW-1:0]   x_q [N+1];
  logic signed [CW-1:0]   y_q [N+1];
  logic [31:0]            z_q [N+1];
  logic [SIDE_W-1:0]      side_q [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      side_q[0] <= side_i;
      if (x_i[CW-1]) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= HALF_TURN;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
      for (int s = 0; s < N; s++) begin
        zero_q[s+1] <= zero_q[s];
        side_q[s+1] <= side_q[s];
        if (!y_q[s][CW-1]) begin
          x_q[s+1] <= x_q[s] + (y_q[s] >>> s);
          y_q[s+1] <= y_q[s] - (x_q[s] >>> s);
          z_q[s+1] <= z_q[s] + ATAN_TAB[s];
        end else begin
          x_q[s+1] <= x_q[s] - (y_q[s] >>> s);
          y_q[s+1] <= y_q[s] + (x_q[s] >>> s);
          z_q[s+1] <= z_q[s] - ATAN_TAB[s];
        end
      end
    end
  end

  assign valid_o = v_q[N];
  assign x_o     = x_q[N];
  assign z_o     = zero_q[N] ? '0 : z_q[N];
  assign side_o  = side_q[N];

endmodule

// ===== hw/rtl/qte_rot.sv =====
// ----------------------------------------------------------------------------
// Rotation CORDIC pipeline
// Cosine and sine of a binary angle; fold stage, then one step per stage.
// ----------------------------------------------------------------------------
module qte_rot #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [31:0]                 angle_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic signed [qte_pkg::CW-1:0] cos_o,
  output logic signed [qte_pkg::CW-1:0] sin_o,
  output logic [SIDE_W-1:0]           side_o
);
  import qte_pkg::*;

  localparam int unsigned N = CORDIC_STEPS;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(34'sd1 <<< 30);
  localparam logic signed [ZW-1:0] HALF    = ZW'(34'sd1 <<< 31);

  logic [N:0]             v_q;
  logic [N:0]             neg_q;
  logic signed [CW-1:0]   x_q [N+1];
  logic signed [CW-1:0]   y_q [N+1];
  logic signed [ZW-1:0]   z_q [N+1];
  logic [SIDE_W-1:0]      side_q [N+1];
  logic signed [ZW-1:0]   z_in;

  assign z_in = ZW'($signed(angle_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CW'(INV_GAIN);
      y_q[0]    <= '0;
      side_q[0] <= side_i;
      if (z_in > QUARTER) begin
        z_q[0]   <= z_in - HALF;
        neg_q[0] <= 1'b1;
      end else if (z_in < -QUARTER) begin
        z_q[0]   <= z_in + HALF;
        neg_q[0] <= 1'b1;
      end else begin
        z_q[0]   <= z_in;
        neg_q[0] <= 1'b0;
      end
      for (int s = 0; s < N; s++) begin
        neg_q[s+1]  <= neg_q[s];
        side_q[s+1] <= side_q[s];
        if (!z_q[s][ZW-1]) begin
          x_q[s+1] <= x_q[s] - (y_q[s] >>> s);
          y_q[s+1] <= y_q[s] + (x_q[s] >>> s);
          z_q[s+1] <= z_q[s] - $signed({2'b00, ATAN_TAB[s]});
        end else begin
          x_q[s+1] <= x_q[s] + (y_q[s] >>> s);
          y_q[s+1] <= y_q[s] - (x_q[s] >>> s);
          z_q[s+1] <= z_q[s] + $signed({2'b00, ATAN_TAB[s]});
        end
      end
    end
  end

  assign valid_o = v_q[N];
  assign cos_o   = neg_q[N] ? -x_q[N] : x_q[N];
  assign sin_o   = neg_q[N] ? -y_q[N] : y_q[N];
  assign side_o  = side_q[N];

endmodule

// ===== hw/rtl/quaternion_to_euler_top.sv =====
// ----------------------------------------------------------------------------
// Quaternion to Euler angles
// Unit quaternion in, three binary angles for the configured axis order out.
// ----------------------------------------------------------------------------
// Slave stream: one quaternion (w, x, y, z) per transfer. Master stream: the
// three angles in tdata, the illegal-order flag in tuser. The axis order is
// set through the cfg write channel (index 0 first, 1 second, 2 third axis)
// while no item is in flight, which the user must keep to; the block does not
// enforce it. The channel is always ready. A quaternion taken on the slave
// side shows up on the master side after two matrix stages, three 31-stage
// CORDIC pipelines (angle of the first axis, middle angle with sine/cosine,
// third angle) and the glue stages between them. While the skid register is
// empty, one quaternion is taken per clock and the pipeline is fully occupied.
// The output register is backed by a skid register. When the receiver
// stalls, one more result lands in the skid register and then the whole
// pipeline and s_axis_tready hold until it drains; nothing is lost.
// Reset empties the pipeline and sets the order to x, y, z.
// ----------------------------------------------------------------------------
module quaternion_to_euler_top #(
  parameter int unsigned ANGLE_BITS     = qte_pkg::ANGLE_BITS_DEF,
  parameter int unsigned COMPONENT_BITS = qte_pkg::COMPONENT_BITS_DEF,
  localparam int unsigned IN_W  = ((4 * COMPONENT_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((3 * ANGLE_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // quat_w, quat_x, quat_y, quat_z from bit 0 up
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // angle_first, angle_second, angle_third from bit 0 up
  output logic [OUT_W-1:0] m_axis_tdata,
  // order_invalid
  output logic             m_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_addr_i,
  input  logic [1:0]       cfg_data_i
);
  import qte_pkg::*;

  localparam int unsigned CB       = COMPONENT_BITS;
  localparam int unsigned ALIGN_SH = (CB <= 31) ? 31 - CB : 0;
  localparam int unsigned RND_SH   = 32 - ANGLE_BITS;
  localparam logic [31:0] RND_HALF = (RND_SH == 0) ? 32'd0 : (32'd1 << (RND_SH - 1));
  localparam logic signed [64:0] ONE60 = 65'sd1 <<< 60;

  typedef struct packed {
    logic       invalid;
    logic       odd;
    logic       proper;
    logic [1:0] ai;
    logic [1:0] aj;
    logic [1:0] ak;
  } ctl_t;

  typedef struct packed {
    logic invalid;
    logic odd;
    logic proper;
    logic signed [MW-1:0] mii;
    logic signed [MW-1:0] mik;
    logic signed [MW-1:0] mjj;
    logic signed [MW-1:0] mkj;
  } sa_t;

  typedef struct packed {
    logic signed [MW-1:0] mjk;
    logic signed [MW-1:0] mkk;
    logic signed [MW-1:0] mki;
    logic signed [MW-1:0] mji;
  } sb_t;

  typedef struct packed {
    logic        invalid;
    logic        odd;
    logic        proper;
    logic        r1neg;
    logic [31:0] r0;
    logic signed [MW-1:0] mjj;
    logic signed [MW-1:0] mkj;
  } sd_t;

  typedef struct packed {
    logic        invalid;
    logic        odd;
    logic [31:0] r0;
    logic [31:0] r1;
  } se_t;

  typedef struct packed {
    logic             inv;
    logic [OUT_W-1:0] data;
  } res_t;

  function automatic logic [1:0] next_axis(logic [1:0] a);
    logic [1:0] r;
    case (a)
      AXIS_X:  r = AXIS_Y;
      AXIS_Y:  r = AXIS_Z;
      AXIS_Z:  r = AXIS_X;
      default: r = AXIS_X;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] prev_axis(logic [1:0] a);
    logic [1:0] r;
    case (a)
      AXIS_X:  r = AXIS_Z;
      AXIS_Y:  r = AXIS_X;
      AXIS_Z:  r = AXIS_Y;
      default: r = AXIS_X;
    endcase
    return r;
  endfunction

  function automatic logic signed [30:0] align(logic [CB-1:0] raw);
    logic signed [30:0] r;
    if (CB <= 31) r = 31'($signed(raw)) <<< ALIGN_SH;
    else          r = 31'($signed(raw) >>> 1);
    return r;
  endfunction

  function automatic logic signed [MW-1:0] diag(logic signed [61:0] a,
                                                logic signed [61:0] b);
    logic signed [64:0] t;
    t = ONE60 - ((65'(a) + 65'(b)) <<< 1);
    return MW'(t >>> 32);
  endfunction

  function automatic logic signed [MW-1:0] offd(logic signed [61:0] a,
                                                logic signed [61:0] b, logic sub);
    logic signed [64:0] t;
    t = sub ? (65'(a) - 65'(b)) : (65'(a) + 65'(b));
    return MW'((t <<< 1) >>> 32);
  endfunction

  function automatic logic signed [MW-1:0] pick(logic [8:0][MW-1:0] m,
                                                logic [1:0] r, logic [1:0] c);
    logic signed [MW-1:0] v;
    case ({r, c})
      {AXIS_X, AXIS_X}: v = m[0];
      {AXIS_X, AXIS_Y}: v = m[1];
      {AXIS_X, AXIS_Z}: v = m[2];
      {AXIS_Y, AXIS_X}: v = m[3];
      {AXIS_Y, AXIS_Y}: v = m[4];
      {AXIS_Y, AXIS_Z}: v = m[5];
      {AXIS_Z, AXIS_X}: v = m[6];
      {AXIS_Z, AXIS_Y}: v = m[7];
      {AXIS_Z, AXIS_Z}: v = m[8];
      default:          v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [ANGLE_BITS-1:0] out_ang(logic [31:0] a, logic neg);
    logic [31:0] t;
    t = (neg ? (32'd0 - a) : a) + RND_HALF;
    return ANGLE_BITS'(t >> RND_SH);
  endfunction

  // configuration
  logic [1:0] first_q, second_q, third_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= AXIS_X;
      second_q <= AXIS_Y;
      third_q  <= AXIS_Z;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_AXIS_FIRST:  first_q  <= cfg_data_i;
        REG_AXIS_SECOND: second_q <= cfg_data_i;
        REG_AXIS_THIRD:  third_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ctl_t ctl_c;
  always_comb begin
    ctl_c.invalid = (first_q > AXIS_Z) || (second_q > AXIS_Z) || (third_q > AXIS_Z) ||
                    (first_q == second_q) || (second_q == third_q);
    ctl_c.odd     = (next_axis(first_q) != second_q);
    ctl_c.proper  = (first_q == third_q);
    ctl_c.ai      = first_q;
    ctl_c.aj      = ctl_c.odd ? prev_axis(first_q) : next_axis(first_q);
    ctl_c.ak      = ctl_c.odd ? next_axis(first_q) : prev_axis(first_q);
  end

  logic en;
  logic skid_v_q;
  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  // stage 1: component products
  logic signed [30:0] qw, qx, qy, qz;
  assign qw = align(s_axis_tdata[0*CB +: CB]);
  assign qx = align(s_axis_tdata[1*CB +: CB]);
  assign qy = align(s_axis_tdata[2*CB +: CB]);
  assign qz = align(s_axis_tdata[3*CB +: CB]);

  logic v1_q, v2_q;
  ctl_t ctl1_q, ctl2_q;
  logic signed [61:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic [8:0][MW-1:0] m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl1_q <= ctl_c;
      xx_q   <= qx * qx;
      yy_q   <= qy * qy;
      zz_q   <= qz * qz;
      xy_q   <= qx * qy;
      xz_q   <= qx * qz;
      yz_q   <= qy * qz;
      wx_q   <= qw * qx;
      wy_q   <= qw * qy;
      wz_q   <= qw * qz;
      // stage 2: rotation matrix, row major
      ctl2_q <= ctl1_q;
      m_q[0] <= diag(yy_q, zz_q);
      m_q[1] <= offd(xy_q, wz_q, 1'b1);
      m_q[2] <= offd(xz_q, wy_q, 1'b0);
      m_q[3] <= offd(xy_q, wz_q, 1'b0);
      m_q[4] <= diag(xx_q, zz_q);
      m_q[5] <= offd(yz_q, wx_q, 1'b1);
      m_q[6] <= offd(xz_q, wy_q, 1'b1);
      m_q[7] <= offd(yz_q, wx_q, 1'b0);
      m_q[8] <= diag(xx_q, yy_q);
    end
  end

  // first angle (and length for the proper-Euler path) / length for Tait-Bryan
  logic [1:0] ai, aj, ak;
  assign ai = ctl2_q.ai;
  assign aj = ctl2_q.aj;
  assign ak = ctl2_q.ak;

  logic signed [CW-1:0] ax_in, ay_in, bx_in, by_in;
  sa_t sa_in, sa_out;
  sb_t sb_in, sb_out;

  always_comb begin
    ax_in = ctl2_q.proper ? CW'(pick(m_q, ak, ai)) : CW'(pick(m_q, ak, ak));
    ay_in = ctl2_q.proper ? CW'(pick(m_q, aj, ai)) : CW'(pick(m_q, aj, ak));
    bx_in = CW'(pick(m_q, ai, ai));
    by_in = CW'(pick(m_q, ai, aj));
    sa_in.invalid = ctl2_q.invalid;
    sa_in.odd     = ctl2_q.odd;
    sa_in.proper  = ctl2_q.proper;
    sa_in.mii     = pick(m_q, ai, ai);
    sa_in.mik     = pick(m_q, ai, ak);
    sa_in.mjj     = pick(m_q, aj, aj);
    sa_in.mkj     = pick(m_q, ak, aj);
    sb_in.mjk     = pick(m_q, aj, ak);
    sb_in.mkk     = pick(m_q, ak, ak);
    sb_in.mki     = pick(m_q, ak, ai);
    sb_in.mji     = pick(m_q, aj, ai);
  end

  logic                 va_o, vb_o;
  logic signed [CW-1:0] xa_o, xb_o;
  logic [31:0]          za_o, zb_o;

  qte_vec #(.SIDE_W($bits(sa_t))) u_vec_a (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q),
    .x_i(ax_in), .y_i(ay_in), .side_i(sa_in),
    .valid_o(va_o), .x_o(xa_o), .z_o(za_o), .side_o(sa_out)
  );

  qte_vec #(.SIDE_W($bits(sb_t))) u_vec_b (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q),
    .x_i(bx_in), .y_i(by_in), .side_i(sb_in),
    .valid_o(vb_o), .x_o(xb_o), .z_o(zb_o), .side_o(sb_out)
  );

  // stage 4: length scaling
  logic signed [33:0] len_x;
  logic signed [65:0] len_p;
  assign len_x = sa_out.proper ? xa_o[33:0] : xb_o[33:0];
  assign len_p = 66'(len_x) * 66'(INV_GAIN);

  logic                 v4_q;
  logic [31:0]          r0_q;
  logic signed [CW-1:0] len_q;
  sa_t                  sa4_q;
  sb_t                  sb4_q;
  logic                 zb_unused;

  assign zb_unused = ^zb_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= va_o && vb_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r0_q  <= za_o;
      len_q <= CW'(len_p >>> 30) ^ CW'(zb_unused & 1'b0);
      sa4_q <= sa_out;
      sb4_q <= sb_out;
    end
  end

  // flip of the first angle, middle angle and sine/cosine of the first angle
  logic                 flip;
  logic [31:0]          r0f;
  logic signed [CW-1:0] cx_in, cy_in;
  sd_t                  sd_in, sd_out;
  sb_t                  sc_out;

  always_comb begin
    flip  = sa4_q.odd ? r0_q[31] : (!r0_q[31] && (r0_q != '0));
    r0f   = flip ? (r0_q + HALF_TURN) : r0_q;
    if (sa4_q.proper) begin
      cx_in = CW'(sa4_q.mii);
      cy_in = len_q;
    end else begin
      cx_in = flip ? -len_q : len_q;
      cy_in = -CW'(sa4_q.mik);
    end
    sd_in.invalid = sa4_q.invalid;
    sd_in.odd     = sa4_q.odd;
    sd_in.proper  = sa4_q.proper;
    sd_in.r1neg   = sa4_q.proper && flip;
    sd_in.r0      = r0f;
    sd_in.mjj     = sa4_q.mjj;
    sd_in.mkj     = sa4_q.mkj;
  end

  logic                 vc_o, vd_o;
  logic signed [CW-1:0] xc_o, c1, s1;
  logic [31:0]          zc_o;

  qte_vec #(.SIDE_W($bits(sb_t))) u_vec_c (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q),
    .x_i(cx_in), .y_i(cy_in), .side_i(sb4_q),
    .valid_o(vc_o), .x_o(xc_o), .z_o(zc_o), .side_o(sc_out)
  );

  qte_rot #(.SIDE_W($bits(sd_t))) u_rot (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q),
    .angle_i(r0f), .side_i(sd_in),
    .valid_o(vd_o), .cos_o(c1), .sin_o(s1), .side_o(sd_out)
  );

  // stage 6: products for the third angle
  logic signed [32:0] c33, s33, op3a, op4a;
  logic signed [MW-1:0] op3b, op4b;
  assign c33  = c1[32:0];
  assign s33  = s1[32:0];
  assign op3a = sd_out.proper ? c33 : s33;
  assign op3b = sd_out.proper ? sc_out.mjk : sc_out.mki;
  assign op4a = sd_out.proper ? s33 : c33;
  assign op4b = sd_out.proper ? sc_out.mkk : sc_out.mji;

  logic               v6_q, v7_q;
  logic signed [66:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [CW-1:0] ex_q, ey_q;
  se_t                se6_q, se7_q;
  logic               xc_unused;

  assign xc_unused = ^xc_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en) begin
      v6_q <= vd_o && vc_o;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q          <= 67'(c33) * 67'(sd_out.mjj);
      p2_q          <= 67'(s33) * 67'(sd_out.mkj);
      p3_q          <= 67'(op3a) * 67'(op3b);
      p4_q          <= 67'(op4a) * 67'(op4b);
      se6_q.invalid <= sd_out.invalid;
      se6_q.odd     <= sd_out.odd;
      se6_q.r0      <= sd_out.r0;
      se6_q.r1      <= (sd_out.r1neg ? (32'd0 - zc_o) : zc_o) ^ {31'd0, xc_unused & 1'b0};
      // stage 7: vector for the third angle
      ex_q          <= CW'((68'(p1_q) - 68'(p2_q)) >>> 30);
      ey_q          <= CW'((68'(p3_q) - 68'(p4_q)) >>> 30);
      se7_q         <= se6_q;
    end
  end

  logic        ve_o;
  logic signed [CW-1:0] xe_o;
  logic [31:0] ze_o;
  se_t         se_out;

  qte_vec #(.SIDE_W($bits(se_t))) u_vec_e (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v7_q),
    .x_i(ex_q), .y_i(ey_q), .side_i(se7_q),
    .valid_o(ve_o), .x_o(xe_o), .z_o(ze_o), .side_o(se_out)
  );

  // stage 8: sign convention, rounding, illegal order
  logic pv_q;
  res_t pd_q;
  res_t res_c;
  logic xe_unused;

  assign xe_unused = ^xe_o;

  always_comb begin
    res_c.inv  = se_out.invalid;
    res_c.data = OUT_W'({out_ang(ze_o, !se_out.odd),
                         out_ang(se_out.r1, !se_out.odd),
                         out_ang(se_out.r0, !se_out.odd)});
    if (se_out.invalid || (xe_unused & 1'b0)) begin
      res_c.data = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en) begin
      pv_q <= ve_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pd_q <= res_c;
    end
  end

  // output register with skid
  logic out_v_q;
  res_t out_q, skid_q;
  logic take;
  assign take = pv_q && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready) begin
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q <= take;
    end else if (take) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (!out_v_q || m_axis_tready) begin
      out_q <= pd_q;
    end else begin
      skid_q <= pd_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q.data;
  assign m_axis_tuser  = out_q.inv;

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds data while output register is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && m_axis_tready) |=> (!skid_v_q && out_v_q))
    else $error("skid register did not drain after a transfer");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("illegal axis order with nonzero angles");

endmodule
